>>> hw/rtl/tlv_pkg.sv
package tlv_pkg;

  // Content bytes kept per content element
  localparam int unsigned MAX_CONTENT_DEF = 1024;

  // Wide enough for any content count in the parameter range, before masking
  localparam int unsigned CNT_EXT_W = 17;

  // Result queue
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = 2;
  localparam int unsigned FIFO_CNT_W = 3;

  // Header size in bytes, counted in the element length
  localparam logic [15:0] HDR_LEN = 16'd4;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_CHAN_EN    = 2'd0,
    CFG_TARGET_TYP = 2'd1,
    CFG_CONTENT_TY = 2'd2,
    CFG_DEF_TARGET = 2'd3
  } cfg_idx_t;

  // Reset values of the configuration registers
  localparam logic        CHAN_EN_RST    = 1'b1;
  localparam logic [15:0] TARGET_TYP_RST = 16'd1601;
  localparam logic [15:0] CONTENT_TY_RST = 16'd1602;
  localparam logic [7:0]  DEF_TARGET_RST = 8'd0;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_SHORT      = 3'd1,
    ST_BAD_LEN    = 3'd2,
    ST_OVERRUN    = 3'd3,
    ST_NO_CONTENT = 3'd4,
    ST_DISABLED   = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    EK_OTHER   = 2'd0,
    EK_TARGET  = 2'd1,
    EK_CONTENT = 2'd2
  } elem_kind_t;

  typedef enum logic {
    RK_CONTENT = 1'b0,
    RK_SUMMARY = 1'b1
  } res_kind_t;

  typedef struct packed {
    res_kind_t   kind;
    logic [7:0]  content_byte;
    logic [9:0]  content_index;
    status_t     status;
    logic [7:0]  target_ident;
    logic        target_seen;
    logic [10:0] content_length;
    logic [10:0] effective_length;
    logic        last_result;
  } result_t;

endpackage

>>> hw/rtl/tlv_message_parser.sv
// Channel  Direction  Handshake            Payload
// in_      input      in_valid/in_stall    in_payload_byte, in_last_byte
// out_     output     out_valid/out_stall  out_kind .. out_last_result
// cfg_     input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One payload byte is taken per cycle while in_stall is low; its parse step and
// result are written in the same cycle into a four-entry result queue register.
// A byte yields at most two results (content byte plus summary). in_stall rises
// when fewer than two queue slots are free; out_stall only backs up the queue.
// rst_n (synchronous) restores the register reset values, clears the message
// state and empties the result queue. cfg_ready is always high.
module tlv_message_parser
  import tlv_pkg::*;
#(
  parameter int unsigned MAX_CONTENT = MAX_CONTENT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_payload_byte,
  input  logic        in_last_byte,

  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [7:0]  out_content_byte,
  output logic [9:0]  out_content_index,
  output logic [2:0]  out_status,
  output logic [7:0]  out_target_ident,
  output logic        out_target_seen,
  output logic [10:0] out_content_length,
  output logic [10:0] out_effective_length,
  output logic        out_last_result,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int unsigned CNT_W = $clog2(MAX_CONTENT + 1);

  // Configuration registers
  logic        chan_en_r;
  logic [15:0] tgt_type_r;
  logic [15:0] cnt_type_r;
  logic [7:0]  def_tgt_r;

  // Message parse state
  logic [1:0]       hdr_cnt_r,   hdr_cnt_nxt;
  logic [23:0]      hdr_r,       hdr_nxt;
  logic [15:0]      body_rem_r,  body_rem_nxt;
  elem_kind_t       ekind_r,     ekind_nxt;
  logic [CNT_W-1:0] ccnt_r,      ccnt_nxt;
  logic [CNT_W-1:0] trim_r,      trim_nxt;
  logic [7:0]       tval_r,      tval_nxt;
  logic             fnd_tgt_r,   fnd_tgt_nxt;
  logic             fnd_cnt_r,   fnd_cnt_nxt;
  status_t          err_r,       err_nxt;
  logic [2:0]       tot_r,       tot_nxt;

  // Result queue
  result_t                 fifo_mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   rd_ptr_r, wr_ptr_r;
  logic [FIFO_CNT_W-1:0]   fifo_cnt_r;

  logic    in_xfer, out_xfer;
  logic    push_data, push_sum;
  result_t data_res, sum_res, head;

  assign cfg_ready = 1'b1;

  // Keep two slots free so a byte that closes the message always fits
  assign in_stall  = (fifo_cnt_r > FIFO_CNT_W'(FIFO_DEPTH - 2));
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = (fifo_cnt_r != '0);
  assign out_xfer  = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_en_r  <= CHAN_EN_RST;
      tgt_type_r <= TARGET_TYP_RST;
      cnt_type_r <= CONTENT_TY_RST;
      def_tgt_r  <= DEF_TARGET_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_CHAN_EN:    chan_en_r  <= cfg_data[0];
        CFG_TARGET_TYP: tgt_type_r <= cfg_data;
        CFG_CONTENT_TY: cnt_type_r <= cfg_data;
        CFG_DEF_TARGET: def_tgt_r  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // One parse step per transferred byte
  always_comb begin
    logic [15:0]          el_type;
    logic [15:0]          el_len;
    logic                 seen;
    status_t              fin_st;
    logic [CNT_EXT_W-1:0] ccnt_ext;
    logic [CNT_EXT_W-1:0] trim_ext;

    hdr_cnt_nxt  = hdr_cnt_r;
    hdr_nxt      = hdr_r;
    body_rem_nxt = body_rem_r;
    ekind_nxt    = ekind_r;
    ccnt_nxt     = ccnt_r;
    trim_nxt     = trim_r;
    tval_nxt     = tval_r;
    fnd_tgt_nxt  = fnd_tgt_r;
    fnd_cnt_nxt  = fnd_cnt_r;
    err_nxt      = err_r;
    tot_nxt      = tot_r;
    push_data    = 1'b0;
    push_sum     = 1'b0;
    data_res     = '0;
    sum_res      = '0;
    el_type      = {hdr_r[15:8], hdr_r[7:0]};
    el_len       = {in_payload_byte, hdr_r[23:16]};
    seen         = 1'b0;
    fin_st       = ST_OK;
    ccnt_ext     = CNT_EXT_W'(ccnt_r);
    trim_ext     = '0;

    if (in_xfer) begin
      if (!chan_en_r) begin
        err_nxt = ST_DISABLED;
      end else if (err_r == ST_OK) begin
        if (body_rem_r != '0) begin
          // Inside an element body
          if (ekind_r == EK_TARGET) begin
            tval_nxt    = in_payload_byte;
            fnd_tgt_nxt = 1'b1;
            ekind_nxt   = EK_OTHER;
          end else if (ekind_r == EK_CONTENT) begin
            if (ccnt_r < CNT_W'(MAX_CONTENT)) begin
              push_data              = 1'b1;
              data_res.kind          = RK_CONTENT;
              data_res.content_byte  = in_payload_byte;
              data_res.content_index = ccnt_ext[9:0];
              data_res.status        = ST_OK;
              if (in_payload_byte != 8'h00) begin
                trim_nxt = ccnt_r + CNT_W'(1);
              end
              ccnt_nxt = ccnt_r + CNT_W'(1);
            end
          end
          body_rem_nxt = body_rem_r - 16'd1;
        end else if (hdr_cnt_r == 2'd3) begin
          // Final header byte: decode type and length
          hdr_cnt_nxt = '0;
          hdr_nxt     = '0;
          ekind_nxt   = EK_OTHER;
          if (el_len < HDR_LEN) begin
            err_nxt = ST_BAD_LEN;
          end else begin
            body_rem_nxt = el_len - HDR_LEN;
            if (el_type == tgt_type_r) begin
              ekind_nxt = EK_TARGET;
            end else if (el_type == cnt_type_r) begin
              ekind_nxt   = EK_CONTENT;
              fnd_cnt_nxt = 1'b1;
              ccnt_nxt    = '0;
              trim_nxt    = '0;
            end
          end
        end else begin
          // Collect header bytes, little-endian
          hdr_cnt_nxt = hdr_cnt_r + 2'd1;
          case (hdr_cnt_r)
            2'd0:    hdr_nxt[7:0]   = in_payload_byte;
            2'd1:    hdr_nxt[15:8]  = in_payload_byte;
            default: hdr_nxt[23:16] = in_payload_byte;
          endcase
        end
      end

      if (tot_nxt < 3'd4) begin
        tot_nxt = tot_r + 3'd1;
      end

      if (in_last_byte) begin
        // An open body at the end of the payload is an overrun
        if (err_nxt == ST_OK && body_rem_nxt != '0) begin
          err_nxt = ST_OVERRUN;
        end
        if (err_nxt == ST_DISABLED) begin
          fin_st = ST_DISABLED;
        end else if (tot_nxt < 3'd4) begin
          fin_st = ST_SHORT;
        end else if (err_nxt != ST_OK) begin
          fin_st = err_nxt;
        end else if (!fnd_cnt_nxt) begin
          fin_st = ST_NO_CONTENT;
        end else begin
          fin_st = ST_OK;
        end

        seen     = fnd_tgt_nxt;
        ccnt_ext = CNT_EXT_W'(ccnt_nxt);
        trim_ext = CNT_EXT_W'(trim_nxt);

        push_sum            = 1'b1;
        sum_res.kind        = RK_SUMMARY;
        sum_res.status      = fin_st;
        sum_res.last_result = 1'b1;
        if (fin_st == ST_OK) begin
          sum_res.target_ident     = seen ? tval_nxt : def_tgt_r;
          sum_res.target_seen      = seen;
          sum_res.content_length   = ccnt_ext[10:0];
          sum_res.effective_length = trim_ext[10:0];
        end else begin
          sum_res.target_ident = def_tgt_r;
        end

        // Drop the message state; the next byte starts a new message
        hdr_cnt_nxt  = '0;
        hdr_nxt      = '0;
        body_rem_nxt = '0;
        ekind_nxt    = EK_OTHER;
        ccnt_nxt     = '0;
        trim_nxt     = '0;
        tval_nxt     = '0;
        fnd_tgt_nxt  = 1'b0;
        fnd_cnt_nxt  = 1'b0;
        err_nxt      = ST_OK;
        tot_nxt      = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_cnt_r  <= '0;
      hdr_r      <= '0;
      body_rem_r <= '0;
      ekind_r    <= EK_OTHER;
      ccnt_r     <= '0;
      trim_r     <= '0;
      tval_r     <= '0;
      fnd_tgt_r  <= 1'b0;
      fnd_cnt_r  <= 1'b0;
      err_r      <= ST_OK;
      tot_r      <= '0;
    end else begin
      hdr_cnt_r  <= hdr_cnt_nxt;
      hdr_r      <= hdr_nxt;
      body_rem_r <= body_rem_nxt;
      ekind_r    <= ekind_nxt;
      ccnt_r     <= ccnt_nxt;
      trim_r     <= trim_nxt;
      tval_r     <= tval_nxt;
      fnd_tgt_r  <= fnd_tgt_nxt;
      fnd_cnt_r  <= fnd_cnt_nxt;
      err_r      <= err_nxt;
      tot_r      <= tot_nxt;
    end
  end

  // Result queue: the content result goes ahead of the summary
  always_ff @(posedge clk) begin
    if (push_data) begin
      fifo_mem_r[wr_ptr_r] <= data_res;
    end
    if (push_sum) begin
      fifo_mem_r[wr_ptr_r + FIFO_PTR_W'(push_data)] <= sum_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
    end else begin
      wr_ptr_r   <= wr_ptr_r + FIFO_PTR_W'(push_data) + FIFO_PTR_W'(push_sum);
      rd_ptr_r   <= rd_ptr_r + FIFO_PTR_W'(out_xfer);
      fifo_cnt_r <= fifo_cnt_r + FIFO_CNT_W'(push_data) + FIFO_CNT_W'(push_sum)
                    - FIFO_CNT_W'(out_xfer);
    end
  end

  assign head                 = fifo_mem_r[rd_ptr_r];
  assign out_kind             = head.kind;
  assign out_content_byte     = head.content_byte;
  assign out_content_index    = head.content_index;
  assign out_status           = head.status;
  assign out_target_ident     = head.target_ident;
  assign out_target_seen      = head.target_seen;
  assign out_content_length   = head.content_length;
  assign out_effective_length = head.effective_length;
  assign out_last_result      = head.last_result;

`ifndef SYNTH
  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_cnt_r <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("result queue count beyond depth");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_last_byte |=> tot_r == '0 && hdr_cnt_r == '0 && err_r == ST_OK)
    else $error("message state not cleared after last byte");

  a_sum_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_last_byte |=> out_valid)
    else $error("summary missing after last byte");

  a_content_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == RK_CONTENT |-> out_status == ST_OK && !out_last_result)
    else $error("content result with status or last flag");
`endif

endmodule

>>> tb/sv/tlv_message_parser_test.sv
`timescale 1ns / 1ps

module tlv_message_parser_test;
  import tlv_pkg::*;

  // Clock, reset and block ports; every input holds a known value from time zero
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_payload_byte = 8'h00;
  logic        in_last_byte = 1'b0;

  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_kind;
  logic [7:0]  out_content_byte;
  logic [9:0]  out_content_index;
  logic [2:0]  out_status;
  logic [7:0]  out_target_ident;
  logic        out_target_seen;
  logic [10:0] out_content_length;
  logic [10:0] out_effective_length;
  logic        out_last_result;

  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_CHAN_EN;
  logic [15:0] cfg_data = 16'h0000;

  always #5 clk = ~clk;

  tlv_message_parser dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_payload_byte      (in_payload_byte),
    .in_last_byte         (in_last_byte),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_kind             (out_kind),
    .out_content_byte     (out_content_byte),
    .out_content_index    (out_content_index),
    .out_status           (out_status),
    .out_target_ident     (out_target_ident),
    .out_target_seen      (out_target_seen),
    .out_content_length   (out_content_length),
    .out_effective_length (out_effective_length),
    .out_last_result      (out_last_result),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  // Register copies, updated on each cfg transfer
  logic        chan_en;
  logic [15:0] target_type;
  logic [15:0] content_type;
  logic [7:0]  default_target;

  // Parser state copy, one message at a time
  int          hdr_count;
  logic [31:0] hdr_bits;
  logic [15:0] body_left;
  elem_kind_t  elem;
  logic [10:0] content_cnt;
  logic [10:0] trim_len;
  logic [7:0]  target_val;
  logic        target_found;
  logic        content_found;
  status_t     msg_err;
  logic [2:0]  byte_cnt;

  // Results the block still owes, oldest first
  result_t     due_results[$];

  // Bytes of the message being built
  logic [7:0]  msg_bytes[$];

  int          fail_count = 0;
  int          bytes_sent = 0;
  // Steady stretches: neither side idles while set
  logic        steady = 1'b0;

  function void clear_message_state();
    hdr_count     = 0;
    hdr_bits      = '0;
    body_left     = '0;
    elem          = EK_OTHER;
    content_cnt   = '0;
    trim_len      = '0;
    target_val    = '0;
    target_found  = 1'b0;
    content_found = 1'b0;
    msg_err       = ST_OK;
    byte_cnt      = '0;
  endfunction

  // Advance the parser copy by one accepted byte and queue what it yields
  function void parse_byte(logic [7:0] b, logic last);
    result_t     r;
    status_t     st;
    logic [15:0] etype;
    logic [15:0] elen;
    if (!chan_en) begin
      msg_err = ST_DISABLED;
    end else if (msg_err == ST_OK) begin
      if (body_left != 0) begin
        if (elem == EK_TARGET) begin
          target_val   = b;
          target_found = 1'b1;
          elem         = EK_OTHER;
        end else if (elem == EK_CONTENT && content_cnt < MAX_CONTENT_DEF) begin
          r               = '0;
          r.kind          = RK_CONTENT;
          r.content_byte  = b;
          r.content_index = content_cnt[9:0];
          r.status        = ST_OK;
          due_results.push_back(r);
          if (b != 8'h00) trim_len = content_cnt + 11'd1;
          content_cnt = content_cnt + 11'd1;
        end
        body_left = body_left - 16'd1;
      end else begin
        hdr_bits[8*hdr_count +: 8] = b;
        hdr_count++;
        if (hdr_count == 4) begin
          etype     = hdr_bits[15:0];
          elen      = hdr_bits[31:16];
          hdr_count = 0;
          hdr_bits  = '0;
          elem      = EK_OTHER;
          if (elen < HDR_LEN) begin
            msg_err = ST_BAD_LEN;
          end else begin
            body_left = elen - HDR_LEN;
            // Target role wins when both type codes match
            if (etype == target_type) begin
              elem = EK_TARGET;
            end else if (etype == content_type) begin
              elem          = EK_CONTENT;
              content_found = 1'b1;
              content_cnt   = '0;
              trim_len      = '0;
            end
          end
        end
      end
    end
    if (byte_cnt < 3'd4) byte_cnt = byte_cnt + 3'd1;

    if (last) begin
      if (msg_err == ST_OK && body_left != 0) msg_err = ST_OVERRUN;
      if (msg_err == ST_DISABLED) st = ST_DISABLED;
      else if (byte_cnt < 3'd4) st = ST_SHORT;
      else if (msg_err != ST_OK) st = msg_err;
      else if (!content_found) st = ST_NO_CONTENT;
      else st = ST_OK;
      r              = '0;
      r.kind         = RK_SUMMARY;
      r.status       = st;
      r.target_ident = default_target;
      r.last_result  = 1'b1;
      if (st == ST_OK) begin
        if (target_found) begin
          r.target_ident = target_val;
          r.target_seen  = 1'b1;
        end
        r.content_length   = content_cnt;
        r.effective_length = trim_len;
      end
      due_results.push_back(r);
      clear_message_state();
    end
  endfunction

  // Offer one byte after a random gap, hold it until the transfer
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = steady ? 0 : ($urandom_range(0, 1) ? 0 : $urandom_range(0, 19));
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_payload_byte <= b;
    in_last_byte    <= last;
    do @(posedge clk); while (!(in_valid && !in_stall));
    parse_byte(b, last);
  endtask

  task automatic send_message();
    for (int i = 0; i < msg_bytes.size(); i++) begin
      send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
    end
    bytes_sent += msg_bytes.size();
  endtask

  // Drop valid and hold off until every owed result has come out
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    // Let a byte that yields nothing clear the pipeline too
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input cfg_idx_t idx, input logic [15:0] data);
    drain_results();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    case (idx)
      CFG_CHAN_EN:    chan_en        = data[0];
      CFG_TARGET_TYP: target_type    = data;
      CFG_CONTENT_TY: content_type   = data;
      CFG_DEF_TARGET: default_target = data[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function void push_header(logic [15:0] etype, logic [15:0] elen);
    msg_bytes.push_back(etype[7:0]);
    msg_bytes.push_back(etype[15:8]);
    msg_bytes.push_back(elen[7:0]);
    msg_bytes.push_back(elen[15:8]);
  endfunction

  // Mostly well-formed messages with random content; some noise, some broken
  function void build_random_message();
    int          n_elem;
    int          data_len;
    int          pick;
    int          drop;
    logic [15:0] etype;
    logic [15:0] elen;
    msg_bytes.delete();
    if ($urandom_range(0, 9) < 2) begin
      repeat ($urandom_range(1, 12)) msg_bytes.push_back(8'($urandom));
      return;
    end
    n_elem = $urandom_range(1, 4);
    for (int i = 0; i < n_elem; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 3) etype = target_type;
      else if (pick < 8) etype = content_type;
      else etype = 16'($urandom);
      data_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if ($urandom_range(0, 29) == 0) elen = 16'($urandom_range(0, 3));
      else elen = 16'(data_len + 4);
      push_header(etype, elen);
      for (int k = 0; k < data_len; k++) begin
        msg_bytes.push_back(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom));
      end
    end
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      // Cut the tail so the last element overruns or its header is left partial
      drop = $urandom_range(1, 3);
      while (drop > 0 && msg_bytes.size() > 1) begin
        void'(msg_bytes.pop_back());
        drop--;
      end
    end else if (pick == 1) begin
      // Leave a partial header at the end
      repeat ($urandom_range(1, 3)) msg_bytes.push_back(8'($urandom));
    end
  endfunction

  task automatic random_messages(input int budget);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      build_random_message();
      send_message();
    end
  endtask

  // Each field at its extremes and each status but ST_DISABLED once, at reset settings
  task automatic test_directed_messages();
    // Target FF, then content 00 FF 00: ok, two results on the last byte
    msg_bytes = '{8'h41, 8'h06, 8'h05, 8'h00, 8'hFF,
                  8'h42, 8'h06, 8'h07, 8'h00, 8'h00, 8'hFF, 8'h00};
    send_message();
    // Too few bytes in total
    msg_bytes = '{8'h42, 8'h06};
    send_message();
    // Header length below the header size
    msg_bytes = '{8'h00, 8'h00, 8'h03, 8'h00};
    send_message();
    // Content body still open at the last byte
    msg_bytes = '{8'h42, 8'h06, 8'h08, 8'h00, 8'h01};
    send_message();
    // No content element, trailing partial header ignored
    msg_bytes = '{8'h00, 8'h00, 8'h04, 8'h00, 8'hAA};
    send_message();
  endtask

  // Short content element, then two past the maximum that restarts at index 0
  task automatic test_long_content();
    msg_bytes.delete();
    push_header(content_type, 16'd6);
    msg_bytes.push_back(8'h5A);
    msg_bytes.push_back(8'h00);
    push_header(content_type, 16'(MAX_CONTENT_DEF + 6));
    for (int k = 0; k < MAX_CONTENT_DEF + 2; k++) begin
      msg_bytes.push_back(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom));
    end
    send_message();
  endtask

  // Walk through register settings, extremes and equal type codes included
  task automatic test_config_sweep();
    write_register(CFG_DEF_TARGET, {8'($urandom), 8'hFF});
    write_register(CFG_TARGET_TYP, 16'h0000);
    write_register(CFG_CONTENT_TY, 16'hFFFF);
    random_messages(40);
    // Same code for both roles: content never opens
    write_register(CFG_CONTENT_TY, 16'h0000);
    random_messages(30);
    write_register(CFG_TARGET_TYP, 16'hFFFF);
    write_register(CFG_DEF_TARGET, {8'($urandom), 8'h00});
    random_messages(40);
    // Disabled channel; upper data bits must be dropped
    write_register(CFG_CHAN_EN, {15'($urandom), 1'b0});
    random_messages(30);
    write_register(CFG_CHAN_EN, {15'($urandom), 1'b1});
    write_register(CFG_TARGET_TYP, 16'($urandom));
    write_register(CFG_CONTENT_TY, 16'($urandom));
    write_register(CFG_DEF_TARGET, 16'($urandom));
    steady = 1'b1;
    random_messages(40);
    steady = 1'b0;
    write_register(CFG_TARGET_TYP, TARGET_TYP_RST);
    write_register(CFG_CONTENT_TY, CONTENT_TY_RST);
  endtask

  // Bulk traffic with the idle mix, steady stretches dropped in at random
  task automatic test_random_traffic(input int budget);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      steady = ($urandom_range(0, 7) == 0);
      build_random_message();
      send_message();
    end
    steady = 1'b0;
  endtask

  // Receiver: draw a stall per result, release, wait for the transfer
  initial begin : result_sink
    int hold;
    forever begin
      hold = steady ? 0 : ($urandom_range(0, 1) ? 0 : $urandom_range(0, 19));
      if (hold > 0) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (hold - 1) @(negedge clk);
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // Compare every transfer on the result channel with the oldest owed result
  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      got.kind             = res_kind_t'(out_kind);
      got.content_byte     = out_content_byte;
      got.content_index    = out_content_index;
      got.status           = status_t'(out_status);
      got.target_ident     = out_target_ident;
      got.target_seen      = out_target_seen;
      got.content_length   = out_content_length;
      got.effective_length = out_effective_length;
      got.last_result      = out_last_result;
      if (due_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result at %0t: kind=%0d byte=%02h idx=%0d st=%0d",
                   $realtime, got.kind, got.content_byte, got.content_index,
                   got.status);
      end else begin
        want = due_results.pop_front();
        if (got !== want) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("mismatch at %0t", $realtime);
            $display({"  expected kind=%0d byte=%02h idx=%0d st=%0d tid=%02h",
                      " seen=%0d clen=%0d elen=%0d last=%0d"},
                     want.kind, want.content_byte, want.content_index, want.status,
                     want.target_ident, want.target_seen, want.content_length,
                     want.effective_length, want.last_result);
            $display({"  actual   kind=%0d byte=%02h idx=%0d st=%0d tid=%02h",
                      " seen=%0d clen=%0d elen=%0d last=%0d"},
                     got.kind, got.content_byte, got.content_index, got.status,
                     got.target_ident, got.target_seen, got.content_length,
                     got.effective_length, got.last_result);
          end
        end
      end
    end
  end

  initial begin
    chan_en        = CHAN_EN_RST;
    target_type    = TARGET_TYP_RST;
    content_type   = CONTENT_TY_RST;
    default_target = DEF_TARGET_RST;
    clear_message_state();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    test_directed_messages();
    test_long_content();
    test_config_sweep();
    test_random_traffic(150);

    // Wait out everything still owed, then keep clocking idle to catch strays
    drain_results();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && due_results.size() == 0) begin
      $display("tlv_message_parser verification clean");
    end else begin
      $display("tlv_message_parser verification failed");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #20_000_000;
    $display("tlv_message_parser verification failed");
    $finish;
  end

endmodule
